>>> hdl/i2dt_pkg.sv
// shared types, constants and helpers for the int64 to decimal text block
`timescale 1ns / 1ps
package i2dt_pkg;

    localparam int VALUE_W      = 64;
    localparam int NUM_DIGITS   = 19;
    localparam int BCD_W        = NUM_DIGITS * 4;
    localparam int CNT_W        = 5;
    localparam int CHAR_W       = 6;
    localparam int INDEX_W      = 10;
    localparam int DABBLE_STEPS = 8;
    localparam int NUM_STAGES   = VALUE_W / DABBLE_STEPS;
    localparam int BUCKET_COUNT_DEFAULT = 1024;

    localparam logic [63:0] HASH_SEED = 64'h100;
    localparam logic [63:0] HASH_MULT = 64'd1111111111111111111;
    localparam logic [7:0]  CHAR_ZERO  = 8'd48;
    localparam logic [7:0]  CHAR_MINUS = 8'd45;

    // one word moving through the conversion pipeline
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
    } conv_word_t;

    // number of significant digits, at least one
    function automatic logic [CNT_W-1:0] digit_len(input logic [BCD_W-1:0] bcd);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                n = CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> hdl/i2dt_dabble_stage.sv
// one pipeline stage of the shift-and-add-3 binary to bcd conversion
`timescale 1ns / 1ps
module i2dt_dabble_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  i2dt_pkg::conv_word_t in_word,
    output i2dt_pkg::conv_word_t out_word
);
    import i2dt_pkg::*;

    conv_word_t word_reg;
    conv_word_t word_next;

    always_comb begin
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        bcd = in_word.bcd;
        bin = in_word.bin;
        for (int s = 0; s < DABBLE_STEPS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (bcd[d*4 +: 4] >= 4'd5) begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
            bin = {bin[VALUE_W-2:0], 1'b0};
        end
        word_next       = in_word;
        word_next.bcd   = bcd;
        word_next.bin   = bin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (en) begin
            word_reg.valid <= in_word.valid;
        end
        if (en) begin
            word_reg.neg <= word_next.neg;
            word_reg.bin <= word_next.bin;
            word_reg.bcd <= word_next.bcd;
        end
    end

    assign out_word = word_reg;

endmodule

>>> hdl/i2dt_serializer.sv
// character emitter with running text hash and output register
`timescale 1ns / 1ps
module i2dt_serializer #(
    parameter int BUCKET_COUNT = i2dt_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  i2dt_pkg::conv_word_t          in_word,
    output logic                          take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2dt_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last,
    output logic [i2dt_pkg::INDEX_W-1:0]  out_index
);
    import i2dt_pkg::*;

    localparam logic [31:0] BUCKET_MASK = 32'(BUCKET_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_ADD  = 3'b100
    } ser_state_t;

    ser_state_t       state_reg, state_next;
    logic [3:0]       digit_store [NUM_DIGITS];
    logic [CNT_W-1:0] pos_reg;
    logic             emit_neg_reg;
    logic [63:0]      hash_reg;
    logic [63:0]      p0_reg;
    logic [31:0]      p1_reg;
    logic [31:0]      p2_reg;
    logic             out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic [7:0]  cur_char;
    logic        cur_last;
    logic [63:0] mix;
    logic [63:0] hash_new;
    logic [31:0] folded;
    logic        slot_free;
    logic        emit;

    assign cur_char  = emit_neg_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit_store[pos_reg]});
    assign cur_last  = !emit_neg_reg && (pos_reg == '0);
    assign mix       = hash_reg ^ {56'd0, cur_char};
    assign hash_new  = p0_reg + {p1_reg + p2_reg, 32'd0};
    assign folded    = hash_new[63:32] ^ hash_new[31:0];
    assign slot_free = !out_valid_reg || m_tready;
    assign take      = (state_reg == S_IDLE) && in_word.valid;
    assign emit      = (state_reg == S_ADD) && slot_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_word.valid) state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  if (slot_free) state_next = cur_last ? S_IDLE : S_MUL;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_store[i] <= in_word.bcd[i*4 +: 4];
            end
            pos_reg      <= digit_len(in_word.bcd) - CNT_W'(1);
            emit_neg_reg <= in_word.neg;
            hash_reg     <= HASH_SEED;
        end
        if (state_reg == S_MUL) begin
            p0_reg <= 64'(mix[31:0] * HASH_MULT[31:0]);
            p1_reg <= 32'(mix[63:32] * HASH_MULT[31:0]);
            p2_reg <= 32'(mix[31:0] * HASH_MULT[63:32]);
        end
        if (emit) begin
            hash_reg      <= hash_new;
            out_char_reg  <= cur_char[CHAR_W-1:0];
            out_last_reg  <= cur_last;
            out_index_reg <= cur_last ? INDEX_W'(folded & BUCKET_MASK) : '0;
            if (emit_neg_reg) begin
                emit_neg_reg <= 1'b0;
            end else if (!cur_last) begin
                pos_reg <= pos_reg - CNT_W'(1);
            end
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_index = out_index_reg;

`ifndef NO_ASSERTIONS
    a_mul_then_add: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |=> state_reg == S_ADD)
        else $error("multiply step not followed by accumulate");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && cur_last |=> state_reg == S_IDLE && out_last_reg)
        else $error("last character did not end the number");
    a_load_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> state_reg == S_MUL && hash_reg == HASH_SEED)
        else $error("hash not seeded on load");
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> out_index_reg == '0)
        else $error("bucket index on a non-final character");
`endif

endmodule

>>> hdl/int64_to_decimal_text_with_bucket_hash.sv
// top level: signed 64-bit integer to decimal ascii text with bucket hash
`timescale 1ns / 1ps
// Takes one signed 64-bit value per input word and returns its decimal text,
// one character per output word, most significant first, with a leading '-'
// for negatives and a single '0' for zero. The input register and eight
// binary-to-bcd stages (8 shift-add-3 steps each) form a 9-deep pipeline that
// can take a new word every cycle while the emitter is free. The emitter
// handles each character with a 32x32 multiply step and an accumulate step
// of the 64-bit hash, and takes the next number only after the last
// character of the current one is emitted. The final character carries
// tlast and the bucket index: the hash folded to 32 bits and masked with
// BUCKET_COUNT-1, zero elsewhere.
module int64_to_decimal_text_with_bucket_hash #(
    parameter int BUCKET_COUNT = i2dt_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] text_char, [15:6] bucket_index
    output logic        m_tlast    // is_last
);
    import i2dt_pkg::*;

    conv_word_t entry_reg;
    conv_word_t stage_word [NUM_STAGES+1];
    logic       adv;
    logic       take;
    logic [CHAR_W-1:0]  out_char;
    logic [INDEX_W-1:0] out_index;

    // whole pipeline moves when its tail is empty or the emitter takes it
    assign adv      = !stage_word[NUM_STAGES].valid || take;
    assign s_tready = adv;

    // input register: magnitude as unsigned two's complement negation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (adv) begin
            entry_reg.valid <= s_tvalid;
        end
        if (adv) begin
            entry_reg.neg <= s_tdata[63];
            entry_reg.bin <= s_tdata[63] ? (~s_tdata + 64'd1) : s_tdata;
            entry_reg.bcd <= '0;
        end
    end

    assign stage_word[0] = entry_reg;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
        i2dt_dabble_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_word  (stage_word[g]),
            .out_word (stage_word[g+1])
        );
    end

    i2dt_serializer #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_word   (stage_word[NUM_STAGES]),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_index (out_index)
    );

    assign m_tdata = {out_index, out_char};

endmodule
